[design/pidb_pkg.sv]
`timescale 1ns / 1ps

package pidb_pkg;

	// request opcodes
	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	// command broadcast to every cell of the row
	typedef struct packed {
		logic ins;
		logic del;
	} cell_cmd_t;

	localparam int unsigned POS_W   = 7;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned COUNT_W = 7;
	localparam int unsigned GROUP   = 8;

endpackage

[design/pidb_if.sv]
`timescale 1ns / 1ps

// request word
interface pidb_req_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   opcode;
	logic [pidb_pkg::POS_W-1:0]   position;
	logic [pidb_pkg::BYTE_W-1:0]  char_in;

	modport source (output valid, opcode, position, char_in, input ready);
	modport sink   (input valid, opcode, position, char_in, output ready);
endinterface

// result word
interface pidb_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          accepted;
	logic [pidb_pkg::BYTE_W-1:0]   char_out;
	logic [pidb_pkg::COUNT_W-1:0]  fill_count;

	modport source (output valid, accepted, char_out, fill_count, input ready);
	modport sink   (input valid, accepted, char_out, fill_count, output ready);
endinterface

[design/positional_insert_delete_buffer_top.sv]
`timescale 1ns / 1ps
// path: a result word passes the stage 1 register and then the output register once its request word is taken
// throughput: one request word per cycle while req.ready is high; the cell row shifts every entry
// at or above the position at once, and the read path is a two-level registered or-tree over the cells
// reset: arst_n clears the fill count and the valid flags; entry bytes are left as they are
// and only positions below the fill count are ever read

module positional_insert_delete_buffer_top #(
	parameter int unsigned CAPACITY = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	pidb_req_if.sink         req,
	pidb_rsp_if.source       rsp
);

	// count holds 0..CAPACITY
	localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
	// compare width covers both the count and the 7-bit position
	localparam int unsigned CMP_W  = (CNT_W > pidb_pkg::POS_W) ? CNT_W : pidb_pkg::POS_W;
	localparam int unsigned NGRP   = (CAPACITY + pidb_pkg::GROUP - 1) / pidb_pkg::GROUP;
	localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

	localparam int unsigned BW = pidb_pkg::BYTE_W;

	// fill count
	logic [CNT_W-1:0] count_q;
	logic [CMP_W-1:0] cnt_ext;
	logic [CMP_W-1:0] pos_ext;
	logic [CMP_W-1:0] pos_eff;

	// decode of the incoming word
	logic             take;
	logic             not_full;
	logic             pos_le_cnt;
	logic             pos_lt_cnt;
	logic             ok;
	logic             rd_ok;
	pidb_pkg::cell_cmd_t cmd;
	logic [CNT_W-1:0] count_nxt;

	// cell row
	logic [BW-1:0] cell_data [CAPACITY];
	logic [BW-1:0] cell_sel  [CAPACITY];

	// stage 1: group or-reduction of the selected byte
	logic              valid_s1;
	logic              ok_s1;
	logic              rd_s1;
	logic [pidb_pkg::COUNT_W-1:0] cnt_s1;
	logic [BW-1:0]     grp_s1 [NGRP];
	logic [BW-1:0]     grp_or [NGRP];
	logic [BW-1:0]     all_or;

	// output register
	logic              out_valid_q;
	logic              accepted_q;
	logic [BW-1:0]     char_q;
	logic [pidb_pkg::COUNT_W-1:0] fill_q;

	logic              adv_out;
	logic              adv_s1;

	assign cnt_ext    = CMP_W'(count_q);
	assign pos_ext    = CMP_W'(req.position);
	assign not_full   = (cnt_ext < CAP_C);
	assign pos_le_cnt = (pos_ext <= cnt_ext);
	assign pos_lt_cnt = (pos_ext < cnt_ext);

	// pipeline flow: the output register frees stage 1, stage 1 frees the input
	assign adv_out   = !out_valid_q || rsp.ready;
	assign adv_s1    = !valid_s1 || adv_out;
	assign req.ready = adv_s1;
	assign take      = req.valid && req.ready;

	// request decode; append is an insert at the fill count
	always_comb begin
		cmd       = '0;
		ok        = 1'b0;
		rd_ok     = 1'b0;
		pos_eff   = pos_ext;
		count_nxt = count_q;
		unique case (pidb_pkg::op_t'(req.opcode))
			pidb_pkg::OP_APPEND: begin
				pos_eff = cnt_ext;
				ok      = not_full;
				cmd.ins = take && not_full;
				if (not_full) begin
					count_nxt = count_q + CNT_W'(1);
				end
			end
			pidb_pkg::OP_INSERT: begin
				ok      = not_full && pos_le_cnt;
				cmd.ins = take && ok;
				if (ok) begin
					count_nxt = count_q + CNT_W'(1);
				end
			end
			pidb_pkg::OP_DELETE: begin
				ok      = pos_lt_cnt;
				cmd.del = take && ok;
				if (ok) begin
					count_nxt = count_q - CNT_W'(1);
				end
			end
			pidb_pkg::OP_READ: begin
				ok    = pos_lt_cnt;
				rd_ok = pos_lt_cnt;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (take) begin
			count_q <= count_nxt;
		end
	end

	// row of cells, each one talks to its neighbors; the end cells see zero past the row edge
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [BW-1:0] left_d;
		logic [BW-1:0] right_d;

		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_mid_l
			assign left_d = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_mid_r
			assign right_d = cell_data[i+1];
		end

		pidb_cell #(
			.IDX_W (CMP_W),
			.INDEX (i)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.pos        (pos_eff),
			.char_in    (req.char_in),
			.left_data  (left_d),
			.right_data (right_d),
			.data       (cell_data[i]),
			.sel_data   (cell_sel[i])
		);
	end

	// first level of the read tree: or over groups of cells
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_or[g] = '0;
			for (int k = 0; k < pidb_pkg::GROUP; k++) begin
				if (g * pidb_pkg::GROUP + k < CAPACITY) begin
					grp_or[g] = grp_or[g] | cell_sel[g * pidb_pkg::GROUP + k];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= take;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (take) begin
			ok_s1  <= ok;
			rd_s1  <= rd_ok;
			cnt_s1 <= pidb_pkg::COUNT_W'(count_nxt);
			for (int g = 0; g < NGRP; g++) begin
				grp_s1[g] <= grp_or[g];
			end
		end
	end

	// second level of the read tree
	always_comb begin
		all_or = '0;
		for (int g = 0; g < NGRP; g++) begin
			all_or = all_or | grp_s1[g];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= valid_s1;
		end
	end

	// output payload; a refused or non-read word gives a zero byte
	always_ff @(posedge clk) begin
		if (adv_out && valid_s1) begin
			accepted_q <= ok_s1;
			char_q     <= rd_s1 ? all_or : '0;
			fill_q     <= cnt_s1;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.accepted   = accepted_q;
	assign rsp.char_out   = char_q;
	assign rsp.fill_count = fill_q;

endmodule

[design/pidb_cell.sv]
`timescale 1ns / 1ps

module pidb_cell #(
	parameter int unsigned IDX_W = 7,
	parameter int unsigned INDEX = 0
) (
	input  logic                         clk,
	input  pidb_pkg::cell_cmd_t          cmd,
	input  logic [IDX_W-1:0]             pos,
	input  logic [pidb_pkg::BYTE_W-1:0]  char_in,
	input  logic [pidb_pkg::BYTE_W-1:0]  left_data,
	input  logic [pidb_pkg::BYTE_W-1:0]  right_data,
	output logic [pidb_pkg::BYTE_W-1:0]  data,
	output logic [pidb_pkg::BYTE_W-1:0]  sel_data
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	logic [pidb_pkg::BYTE_W-1:0] data_q;
	logic                        at_pos;
	logic                        above_pos;

	assign at_pos    = (MY_IDX == pos);
	assign above_pos = (MY_IDX > pos);

	// payload only, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (at_pos) begin
				data_q <= char_in;
			end else if (above_pos) begin
				data_q <= left_data;
			end
		end else if (cmd.del) begin
			if (at_pos || above_pos) begin
				data_q <= right_data;
			end
		end
	end

	assign data     = data_q;
	assign sel_data = at_pos ? data_q : '0;

endmodule
